/* sv/bml_pkg.sv */
// Shared types and constants for the bilinear map lookup core.
package bml_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_WR_X    = 2'd1,
    OP_WR_Y    = 2'd2,
    OP_WR_CELL = 2'd3
  } op_t;

  localparam logic REG_X_COUNT = 1'b0;
  localparam logic REG_Y_COUNT = 1'b1;

  localparam int CNT_W   = 5;
  localparam int RES_W   = 24;
  localparam int CHUNK_W = 12;
  localparam int Q_BITS  = 24;

  typedef struct packed {
    op_t                op;
    logic [7:0]         index;
    logic signed [15:0] wval;
    logic signed [23:0] x;
    logic signed [23:0] y;
  } item_t;

endpackage

/* sv/bml_front.sv */
// Front end: accepts commands, decodes the function and drops out-of-range writes.
module bml_front #(
  parameter int MAX_X = 16,
  parameter int MAX_Y = 16
) (
  input  logic                start,
  input  logic                full,
  input  logic [1:0]          func,
  input  logic [7:0]          index,
  input  logic signed [15:0]  write_value,
  input  logic signed [23:0]  x_value,
  input  logic signed [23:0]  y_value,
  output logic                busy,
  output logic                push,
  output bml_pkg::item_t      item
);

  localparam logic [16:0] X_LIM = 17'(MAX_X);
  localparam logic [16:0] Y_LIM = 17'(MAX_Y);
  localparam logic [16:0] C_LIM = 17'(MAX_X * MAX_Y);

  logic [16:0] idx_w;
  logic        keep;

  assign idx_w = {9'd0, index};

  always_comb begin
    unique case (bml_pkg::op_t'(func))
      bml_pkg::OP_LOOKUP:  keep = 1'b1;
      bml_pkg::OP_WR_X:    keep = idx_w < X_LIM;
      bml_pkg::OP_WR_Y:    keep = idx_w < Y_LIM;
      bml_pkg::OP_WR_CELL: keep = idx_w < C_LIM;
      default:             keep = 1'b0;
    endcase
  end

  assign busy       = full;
  assign push       = start && !full && keep;
  assign item.op    = bml_pkg::op_t'(func);
  assign item.index = index;
  assign item.wval  = write_value;
  assign item.x     = x_value;
  assign item.y     = y_value;

endmodule

/* sv/bml_queue.sv */
// Two-entry command queue between the front end and the lookup engine.
module bml_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bml_pkg::item_t item,
  input  logic           pop,
  output bml_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  bml_pkg::item_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign empty = count == 2'd0;
  assign full  = count == 2'd2;
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

/* sv/bml_back.sv */
// Lookup engine: map storage, axis search, weighted sum and rounding divider.
module bml_back #(
  parameter int MAX_X = 16,
  parameter int MAX_Y = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [4:0]            cfg_data,
  input  logic                  empty,
  input  bml_pkg::item_t        head,
  output logic                  pop,
  output logic                  done,
  output logic signed [23:0]    result
);

  localparam int XAW = $clog2(MAX_X);
  localparam int YAW = $clog2(MAX_Y);
  localparam int AW  = (XAW > YAW) ? XAW : YAW;
  localparam int CAW = $clog2(MAX_X * MAX_Y);
  localparam int CFW = AW + 8;
  localparam int AC_W = 66;
  localparam int AR_W = 42;
  localparam int Q_BITS_L = bml_pkg::Q_BITS;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_RD0   = 14'b00000000000010,
    S_CK0   = 14'b00000000000100,
    S_CKN   = 14'b00000000001000,
    S_LOOP  = 14'b00000000010000,
    S_CKM   = 14'b00000000100000,
    S_FIN   = 14'b00000001000000,
    S_CRD   = 14'b00000010000000,
    S_CM0   = 14'b00000100000000,
    S_CM1   = 14'b00001000000000,
    S_RM0   = 14'b00010000000000,
    S_RM1   = 14'b00100000000000,
    S_DINIT = 14'b01000000000000,
    S_DIV   = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // map storage
  logic signed [15:0] x_bp  [MAX_X];
  logic signed [15:0] y_bp  [MAX_Y];
  logic signed [15:0] cells [MAX_X * MAX_Y];
  logic signed [15:0] x_rd;
  logic signed [15:0] y_rd;
  logic signed [15:0] cdata;

  logic [4:0]  x_count;
  logic [4:0]  y_count;
  logic [6:0]  nx;
  logic [6:0]  ny;

  // search state
  logic               axis;
  logic [AW-1:0]      a;
  logic [AW-1:0]      b;
  logic signed [15:0] pa;
  logic signed [15:0] pb;
  logic signed [23:0] vx;
  logic signed [23:0] vy;
  logic [AW-1:0]      lo   [2];
  logic [AW-1:0]      hi   [2];
  logic [23:0]        wlo  [2];
  logic [23:0]        whi  [2];
  logic [15:0]        span [2];

  // arithmetic state
  logic                   row;
  logic                   col;
  logic signed [AR_W-1:0] acc_r;
  logic signed [AC_W-1:0] acc;
  logic [31:0]            den;
  logic [AC_W-1:0]        rem;
  logic [AC_W-1:0]        dsh;
  logic [Q_BITS_L-1:0]    q;
  logic [4:0]             cnt;
  logic                   neg;

  // combinational helpers
  logic [6:0]         n_cur;
  logic [AW-1:0]      nm1;
  logic [AW-1:0]      mid;
  logic [AW-1:0]      bp_addr;
  logic signed [23:0] v_cur;
  logic signed [15:0] bp_rd;
  logic signed [23:0] bp_q8;
  logic signed [23:0] pa_q8;
  logic signed [23:0] pb_q8;
  logic signed [23:0] vcl;
  logic signed [24:0] wlo_d;
  logic signed [24:0] whi_d;
  logic signed [16:0] span_d;
  logic               collapse;
  logic [AW-1:0]      row_idx;
  logic [AW-1:0]      col_idx;
  logic [CFW-1:0]     caddr_full;
  logic [CAW-1:0]     caddr;
  logic               cm_phase;
  logic               hi_chunk;
  logic signed [AR_W-1:0] mac_a;
  logic [23:0]        w_cur;
  logic [bml_pkg::CHUNK_W-1:0] chunk;
  logic signed [AR_W+bml_pkg::CHUNK_W:0] prod;
  logic signed [AC_W-1:0] prod_w;
  logic [AC_W-1:0]    mag;
  logic               ge;
  logic [Q_BITS_L-1:0] q_fin;

  assign nx = (x_count < 5'd2) ? 7'd2 :
              ({2'b0, x_count} > 7'(MAX_X)) ? 7'(MAX_X) : {2'b0, x_count};
  assign ny = (y_count < 5'd2) ? 7'd2 :
              ({2'b0, y_count} > 7'(MAX_Y)) ? 7'(MAX_Y) : {2'b0, y_count};

  assign n_cur = axis ? ny : nx;
  assign nm1   = AW'(n_cur - 7'd1);
  assign mid   = AW'(({1'b0, a} + {1'b0, b}) >> 1);
  assign v_cur = axis ? vy : vx;
  assign bp_rd = axis ? y_rd : x_rd;
  assign bp_q8 = {bp_rd, 8'b0};
  assign pa_q8 = {pa, 8'b0};
  assign pb_q8 = {pb, 8'b0};

  always_comb begin
    unique case (state)
      S_RD0:   bp_addr = '0;
      S_CK0:   bp_addr = nm1;
      S_LOOP:  bp_addr = mid;
      default: bp_addr = '0;
    endcase
  end

  // clamp into the bracketing pair before weighting
  assign vcl      = (v_cur < pa_q8) ? pa_q8 : (v_cur > pb_q8) ? pb_q8 : v_cur;
  assign wlo_d    = {pb_q8[23], pb_q8} - {vcl[23], vcl};
  assign whi_d    = {vcl[23], vcl} - {pa_q8[23], pa_q8};
  assign span_d   = {pb[15], pb} - {pa[15], pa};
  assign collapse = (a == b) || (pb <= pa);

  assign row_idx    = row ? hi[1] : lo[1];
  assign col_idx    = col ? hi[0] : lo[0];
  assign caddr_full = CFW'(row_idx) * CFW'(nx) + CFW'(col_idx);
  assign caddr      = caddr_full[CAW-1:0];

  // one shared multiplier: cell times X weight, then row sum times Y weight
  assign cm_phase = (state == S_CM0) || (state == S_CM1);
  assign hi_chunk = (state == S_CM1) || (state == S_RM1);
  assign mac_a    = cm_phase ? AR_W'(cdata) : acc_r;
  assign w_cur    = cm_phase ? (col ? whi[0] : wlo[0]) : (row ? whi[1] : wlo[1]);
  assign chunk    = hi_chunk ? w_cur[23:12] : w_cur[11:0];
  assign prod     = mac_a * $signed({1'b0, chunk});
  assign prod_w   = hi_chunk ? (AC_W'(prod) <<< bml_pkg::CHUNK_W) : AC_W'(prod);

  assign mag   = acc[AC_W-1] ? AC_W'(-acc) : AC_W'(acc);
  assign ge    = rem >= dsh;
  assign q_fin = {q[Q_BITS_L-2:0], ge};

  assign pop = (state == S_IDLE) && !empty;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (pop && head.op == bml_pkg::OP_LOOKUP) state_next = S_RD0;
      S_RD0:   state_next = S_CK0;
      S_CK0:   state_next = (v_cur <= bp_q8) ? S_FIN : S_CKN;
      S_CKN:   state_next = (v_cur >= bp_q8) ? S_FIN : S_LOOP;
      S_LOOP:  state_next = ((b - a) > AW'(1)) ? S_CKM : S_FIN;
      S_CKM:   state_next = S_LOOP;
      S_FIN:   state_next = axis ? S_CRD : S_RD0;
      S_CRD:   state_next = S_CM0;
      S_CM0:   state_next = S_CM1;
      S_CM1:   state_next = col ? S_RM0 : S_CRD;
      S_RM0:   state_next = S_RM1;
      S_RM1:   state_next = row ? S_DINIT : S_CRD;
      S_DINIT: state_next = S_DIV;
      S_DIV:   state_next = (cnt == 5'd0) ? S_IDLE : S_DIV;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && head.op == bml_pkg::OP_WR_X) x_bp[XAW'(head.index)] <= head.wval;
    if (pop && head.op == bml_pkg::OP_WR_Y) y_bp[YAW'(head.index)] <= head.wval;
    if (pop && head.op == bml_pkg::OP_WR_CELL) begin
      cells[CAW'({{CAW{1'b0}}, head.index})] <= head.wval;
    end
    x_rd <= x_bp[bp_addr[XAW-1:0]];
    y_rd <= y_bp[bp_addr[YAW-1:0]];
    if (state == S_CRD) cdata <= cells[caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      x_count <= 5'd16;
      y_count <= 5'd16;
    end else begin
      state <= state_next;
      done  <= (state == S_DIV) && (cnt == 5'd0);
      if (cfg_write) begin
        unique case (cfg_index)
          bml_pkg::REG_X_COUNT: x_count <= cfg_data;
          bml_pkg::REG_Y_COUNT: y_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        vx   <= head.x;
        vy   <= head.y;
        axis <= 1'b0;
      end
      S_CK0: begin
        if (v_cur <= bp_q8) begin
          a <= '0;
          b <= '0;
        end else begin
          pa <= bp_rd;
        end
      end
      S_CKN: begin
        if (v_cur >= bp_q8) begin
          a <= nm1;
          b <= nm1;
        end else begin
          pb <= bp_rd;
          a  <= '0;
          b  <= nm1;
        end
      end
      S_CKM: begin
        if (v_cur < bp_q8) begin
          b  <= mid;
          pb <= bp_rd;
        end else if (v_cur > bp_q8) begin
          a  <= mid;
          pa <= bp_rd;
        end else begin
          a  <= mid;
          b  <= mid;
          pa <= bp_rd;
          pb <= bp_rd;
        end
      end
      S_FIN: begin
        lo[axis] <= a;
        if (collapse) begin
          hi[axis]   <= a;
          wlo[axis]  <= 24'd256;
          whi[axis]  <= 24'd0;
          span[axis] <= 16'd1;
        end else begin
          hi[axis]   <= b;
          wlo[axis]  <= wlo_d[23:0];
          whi[axis]  <= whi_d[23:0];
          span[axis] <= span_d[15:0];
        end
        axis  <= 1'b1;
        row   <= 1'b0;
        col   <= 1'b0;
        acc   <= '0;
        acc_r <= '0;
      end
      S_CRD: den <= span[0] * span[1];
      S_CM0: acc_r <= acc_r + AR_W'(prod_w);
      S_CM1: begin
        acc_r <= acc_r + AR_W'(prod_w);
        col   <= ~col;
      end
      S_RM0: acc <= acc + prod_w;
      S_RM1: begin
        acc   <= acc + prod_w;
        acc_r <= '0;
        row   <= 1'b1;
      end
      S_DINIT: begin
        // add half the divisor so the quotient rounds to nearest
        neg <= acc[AC_W-1];
        rem <= mag + AC_W'({den, 7'b0});
        dsh <= AC_W'({den, 31'b0});
        q   <= '0;
        cnt <= 5'(Q_BITS_L - 1);
      end
      S_DIV: begin
        if (ge) rem <= rem - dsh;
        dsh <= dsh >> 1;
        q   <= q_fin;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) result <= neg ? -$signed(q_fin) : $signed(q_fin);
      end
      default: ;
    endcase
  end

endmodule

/* sv/bilinear_map_lookup_core.sv */
// Top level of the bilinear calibration map lookup core.
//
//  channel   signals                                      direction
//  command   start busy func index write_value x/y_value  in, taken when start && !busy
//  result    done result                                  out, one-cycle strobe
//  config    cfg_write cfg_index cfg_data                 in, written at once
//
// A write leaves the queue when the engine is idle and the write is at its head. A lookup
// holds the engine for a search on each axis, the weighted sum and the rounding divider:
// an axis search ends at the first breakpoint when it clamps low, at the last when it
// clamps high, and else after halving steps over the breakpoints.
// The two-entry queue takes commands during a lookup; busy is high while it is full.
// Reset clears queue and engine control and sets both counts to 16; results never stall.
module bilinear_map_lookup_core #(
  parameter int MAX_X = 16,
  parameter int MAX_Y = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [7:0]         index,
  input  logic signed [15:0] write_value,
  input  logic signed [23:0] x_value,
  input  logic signed [23:0] y_value,
  output logic               done,
  output logic signed [23:0] result,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);

  bml_pkg::item_t item;
  bml_pkg::item_t head;
  logic           push;
  logic           pop;
  logic           empty;
  logic           full;

  bml_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_front (
    .start(start), .full(full), .func(func), .index(index),
    .write_value(write_value), .x_value(x_value), .y_value(y_value),
    .busy(busy), .push(push), .item(item)
  );

  bml_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .item(item), .pop(pop),
    .head(head), .empty(empty), .full(full)
  );

  bml_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_back (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .empty(empty), .head(head), .pop(pop),
    .done(done), .result(result)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_reset_free: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("queue or engine not idle after reset");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("transfer pushed into a full queue");

endmodule
